// ----- rtl/core/fla_pkg.sv -----
// fla_pkg: shared constants, codes and types of the free list allocator
// no dependencies; used by fla_free_table and free_list_allocator
package fla_pkg;

    localparam int FREE_ENTRIES_DEF  = 32;
    localparam int ALLOC_ENTRIES_DEF = 32;
    localparam int HEADER_BYTES_DEF  = 16;
    localparam int ADDR_BITS_DEF     = 16;

    // request operations
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // configuration register index, taken from paddr[2]
    localparam logic REG_FIT_POLICY  = 1'b0;
    localparam logic REG_ARENA_BYTES = 1'b1;

    localparam logic [16:0] ARENA_RESET = 17'h10000;

    // free table update controls
    typedef struct packed {
        logic init;
        logic wr_en;
        logic shift_dn;
        logic shift_up;
        logic cnt_inc;
        logic cnt_dec;
    } fla_ft_ctrl_t;

endpackage

// ----- rtl/core/fla_span_calc.sv -----
// fla_span_calc: shared fit unit, evaluates one free block against a request
// depends on nothing but its parameters; instanced once by the top level
module fla_span_calc #(
    parameter int ADDR_BITS    = 16,
    parameter int HEADER_BYTES = 16
) (
    input  logic [ADDR_BITS-1:0] base,
    input  logic [ADDR_BITS:0]   size,
    input  logic [16:0]          req,
    input  logic [3:0]           lg,
    output logic                 fits,
    output logic [ADDR_BITS:0]   pad,
    output logic [ADDR_BITS:0]   need,
    output logic [ADDR_BITS:0]   left
);
    localparam int XW = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 2;
    localparam int NW = XW + 2;

    logic [XW-1:0] t;
    logic [XW-1:0] aligned;
    logic [XW-1:0] pad_x;
    logic [NW-1:0] need_x;
    logic [NW-1:0] size_x;
    logic [16:0]   req_eff;

    always_comb begin
        req_eff = (req == 17'd0) ? 17'd1 : req;
        t       = XW'(base) + XW'(HEADER_BYTES) + (XW'(1) << lg) - XW'(1);
        aligned = (t >> lg) << lg;
        pad_x   = aligned - XW'(base);
        need_x  = NW'(req_eff) + NW'(pad_x);
        size_x  = NW'(size);
        fits    = size_x >= need_x;
        pad     = pad_x[ADDR_BITS:0];
        need    = need_x[ADDR_BITS:0];
        left    = size - need_x[ADDR_BITS:0];
    end
endmodule

// ----- rtl/core/fla_free_table.sv -----
// fla_free_table: address-ordered table of free blocks with in-place shift
// depends on fla_pkg for the update control struct
module fla_free_table #(
    parameter int FREE_ENTRIES = 32,
    parameter int ADDR_BITS    = 16,
    localparam int FIW = $clog2(FREE_ENTRIES),
    localparam int CW  = $clog2(FREE_ENTRIES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [FIW-1:0]       rd_idx,
    output logic [ADDR_BITS-1:0] rd_start,
    output logic [ADDR_BITS:0]   rd_size,
    input  fla_pkg::fla_ft_ctrl_t ctrl,
    input  logic [FIW-1:0]       wr_idx,
    input  logic [FIW-1:0]       sh_idx,
    input  logic [ADDR_BITS-1:0] wr_start,
    input  logic [ADDR_BITS:0]   wr_size,
    output logic [CW-1:0]        count
);
    localparam logic [ADDR_BITS:0] RST_SIZE =
        (ADDR_BITS >= 16) ? (ADDR_BITS+1)'(65536) : (ADDR_BITS+1)'(1) << ADDR_BITS;

    logic [ADDR_BITS-1:0] start_reg [FREE_ENTRIES];
    logic [ADDR_BITS:0]   size_reg  [FREE_ENTRIES];
    logic [ADDR_BITS-1:0] hi_start  [FREE_ENTRIES];
    logic [ADDR_BITS:0]   hi_size   [FREE_ENTRIES];
    logic [ADDR_BITS-1:0] lo_start  [FREE_ENTRIES];
    logic [ADDR_BITS:0]   lo_size   [FREE_ENTRIES];
    logic [CW-1:0]        count_reg;

    assign rd_start = start_reg[rd_idx];
    assign rd_size  = size_reg[rd_idx];
    assign count    = count_reg;

    for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_ent
        if (g < FREE_ENTRIES - 1) begin : g_hi
            assign hi_start[g] = start_reg[g+1];
            assign hi_size[g]  = size_reg[g+1];
        end else begin : g_hi_end
            assign hi_start[g] = start_reg[g];
            assign hi_size[g]  = size_reg[g];
        end
        if (g > 0) begin : g_lo
            assign lo_start[g] = start_reg[g-1];
            assign lo_size[g]  = size_reg[g-1];
        end else begin : g_lo_end
            assign lo_start[g] = start_reg[g];
            assign lo_size[g]  = size_reg[g];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn && g == 0) begin
                start_reg[g] <= '0;
                size_reg[g]  <= RST_SIZE;
            end else if (ctrl.init && g == 0) begin
                start_reg[g] <= '0;
                size_reg[g]  <= wr_size;
            end else if (ctrl.wr_en && wr_idx == FIW'(g)) begin
                start_reg[g] <= wr_start;
                size_reg[g]  <= wr_size;
            end else if (ctrl.shift_dn && FIW'(g) >= sh_idx) begin
                start_reg[g] <= hi_start[g];
                size_reg[g]  <= hi_size[g];
            end else if (ctrl.shift_up && FIW'(g) > sh_idx) begin
                start_reg[g] <= lo_start[g];
                size_reg[g]  <= lo_size[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(1);
        end else begin
            priority if (ctrl.init) begin
                count_reg <= (wr_size != '0) ? CW'(1) : '0;
            end else if (ctrl.cnt_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (ctrl.cnt_dec) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end
endmodule

// ----- rtl/core/free_list_allocator.sv -----
// free_list_allocator: top level, request sequencer, allocation table, apb registers
// depends on fla_pkg, fla_span_calc and fla_free_table
//
//  channel   dir  handshake               word
//  s_*       in   s_tvalid / s_tready     op, request_bytes, align_log2, free_address
//  m_*       out  m_tvalid / m_tready     data_address, status, used_bytes
//  apb       in   psel, penable, pready   fit_policy @0x0, arena_bytes @0x4
//
// allocate: the free table walk and the search for the first idle allocation slot run side by side;
// the free table walk reads one entry a cycle through the shared fit unit, the slot search one slot a cycle
// free: the allocation table is searched for the address, then the free table is scanned
// reinitialise clears the allocation table and reloads the free table; s_tready is low while a request runs
// reset is synchronous; the arena starts as one block of 65536 bytes
// a finished word waits in the output register while the next request is taken;
// a word still waiting there holds the sequencer in its last state
module free_list_allocator #(
    parameter int FREE_ENTRIES  = fla_pkg::FREE_ENTRIES_DEF,
    parameter int ALLOC_ENTRIES = fla_pkg::ALLOC_ENTRIES_DEF,
    parameter int HEADER_BYTES  = fla_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS     = fla_pkg::ADDR_BITS_DEF,
    localparam int S_W = ((23 + ADDR_BITS + 7) / 8) * 8,
    localparam int M_W = ((2 * ADDR_BITS + 3 + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // op, request_bytes, align_log2, free_address (lowest first)
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // data_address, status, used_bytes (lowest first)
    output logic [M_W-1:0] m_tdata,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    localparam int A   = ADDR_BITS;
    localparam int FIW = $clog2(FREE_ENTRIES);
    localparam int CW  = $clog2(FREE_ENTRIES + 1);
    localparam int AIW = $clog2(ALLOC_ENTRIES);
    localparam int CLW = (A + 1 > 17) ? A + 1 : 17;

    typedef enum logic [2:0] {
        S_IDLE, S_A_SCAN, S_A_COMMIT, S_F_FIND, S_F_SCAN, S_F_COMMIT, S_INIT, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic        fit_policy_reg;
    logic [16:0] arena_reg;

    // request
    logic [1:0]  op;
    logic [16:0] req_in;
    logic [3:0]  lg_in;
    logic [A-1:0] faddr_in;
    logic [16:0] req_reg;
    logic [3:0]  lg_reg;
    logic [A-1:0] faddr_reg;

    // allocation table
    logic [A-1:0] al_data_reg [ALLOC_ENTRIES];
    logic [A:0]   al_size_reg [ALLOC_ENTRIES];
    logic [A:0]   al_pad_reg  [ALLOC_ENTRIES];
    logic [ALLOC_ENTRIES-1:0] al_valid_reg;
    logic [A:0]   used_reg;

    // scan state
    logic [CW-1:0]  scan_reg;
    logic [AIW-1:0] slot_reg;
    logic           slot_done_reg, slot_full_reg;
    logic           fit_done_reg, found_reg;
    logic [FIW-1:0] pick_reg;
    logic [A-1:0]   best_base_reg;
    logic [A:0]     best_left_reg, best_need_reg, best_pad_reg;
    logic [A-1:0]   f_base_reg;
    logic [A:0]     f_size_reg;
    logic [AIW-1:0] f_slot_reg;
    logic           have_prev_reg, mp_reg, mn_reg;
    logic [A-1:0]   prev_start_reg;
    logic [A:0]     prev_size_reg, next_size_reg;

    // result
    logic [A-1:0] res_addr_reg;
    logic [1:0]   res_status_reg;
    logic         m_tvalid_reg;
    logic [A-1:0] m_addr_reg;
    logic [1:0]   m_status_reg;
    logic [A:0]   m_used_reg;

    // free table and fit unit
    logic [A-1:0]  rd_start;
    logic [A:0]    rd_size;
    logic [CW-1:0] ft_count;
    fla_pkg::fla_ft_ctrl_t ft_ctrl;
    logic [FIW-1:0] wr_idx, sh_idx;
    logic [A-1:0]  wr_start;
    logic [A:0]    wr_size;
    logic          c_fits;
    logic [A:0]    c_pad, c_need, c_left;

    logic          scan_live;
    logic          accept;
    logic [A:0]    prev_end, f_end, new_data_x;
    logic          f_full;
    logic [CLW-1:0] ar_ext, ar_lim, ar_clamp;

    assign op       = s_tdata[1:0];
    assign req_in   = s_tdata[18:2];
    assign lg_in    = s_tdata[22:19];
    assign faddr_in = s_tdata[23 +: A];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_W'({m_used_reg, m_status_reg, m_addr_reg});
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == fla_pkg::REG_ARENA_BYTES) ? 32'(arena_reg)
                                                             : 32'(fit_policy_reg);

    fla_free_table #(.FREE_ENTRIES(FREE_ENTRIES), .ADDR_BITS(A)) u_ft (
        .aclk(aclk), .aresetn(aresetn),
        .rd_idx(scan_reg[FIW-1:0]), .rd_start(rd_start), .rd_size(rd_size),
        .ctrl(ft_ctrl), .wr_idx(wr_idx), .sh_idx(sh_idx),
        .wr_start(wr_start), .wr_size(wr_size), .count(ft_count)
    );

    fla_span_calc #(.ADDR_BITS(A), .HEADER_BYTES(HEADER_BYTES)) u_calc (
        .base(rd_start), .size(rd_size), .req(req_reg), .lg(lg_reg),
        .fits(c_fits), .pad(c_pad), .need(c_need), .left(c_left)
    );

    always_comb begin
        scan_live  = scan_reg < ft_count;
        prev_end   = {1'b0, prev_start_reg} + prev_size_reg;
        f_end      = {1'b0, f_base_reg} + f_size_reg;
        new_data_x = {1'b0, best_base_reg} + best_pad_reg;
        f_full     = !mp_reg && !mn_reg && (ft_count >= CW'(FREE_ENTRIES));
        ar_ext     = CLW'(arena_reg);
        ar_lim     = CLW'(1) << A;
        ar_clamp   = (ar_ext > ar_lim) ? ar_lim : ar_ext;

        ft_ctrl  = '0;
        wr_idx   = pick_reg;
        sh_idx   = pick_reg;
        wr_start = '0;
        wr_size  = '0;
        unique case (state_reg)
            S_A_COMMIT: begin
                wr_start = best_base_reg + best_need_reg[A-1:0];
                wr_size  = best_left_reg;
                if (found_reg && !slot_full_reg) begin
                    if (best_left_reg != '0) begin
                        ft_ctrl.wr_en = 1'b1;
                    end else begin
                        ft_ctrl.shift_dn = 1'b1;
                        ft_ctrl.cnt_dec  = 1'b1;
                    end
                end
            end
            S_F_COMMIT: begin
                sh_idx   = scan_reg[FIW-1:0];
                wr_idx   = mp_reg ? scan_reg[FIW-1:0] - FIW'(1) : scan_reg[FIW-1:0];
                wr_start = mp_reg ? prev_start_reg : f_base_reg;
                priority if (mp_reg && mn_reg) begin
                    wr_size          = prev_size_reg + f_size_reg + next_size_reg;
                    ft_ctrl.wr_en    = 1'b1;
                    ft_ctrl.shift_dn = 1'b1;
                    ft_ctrl.cnt_dec  = 1'b1;
                end else if (mp_reg) begin
                    wr_size       = prev_size_reg + f_size_reg;
                    ft_ctrl.wr_en = 1'b1;
                end else if (mn_reg) begin
                    wr_size       = f_size_reg + next_size_reg;
                    ft_ctrl.wr_en = 1'b1;
                end else begin
                    wr_size          = f_size_reg;
                    ft_ctrl.wr_en    = !f_full;
                    ft_ctrl.shift_up = !f_full;
                    ft_ctrl.cnt_inc  = !f_full;
                end
            end
            S_INIT: begin
                wr_size      = ar_clamp[A:0];
                ft_ctrl.init = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            al_valid_reg   <= '0;
            used_reg       <= '0;
            fit_policy_reg <= 1'b0;
            arena_reg      <= fla_pkg::ARENA_RESET;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == fla_pkg::REG_ARENA_BYTES) arena_reg <= pwdata[16:0];
                else fit_policy_reg <= pwdata[0];
            end
            // the done state loads a fresh word itself
            if (m_tready && state_reg != S_DONE) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg        <= req_in;
                        lg_reg         <= lg_in;
                        faddr_reg      <= faddr_in;
                        res_addr_reg   <= '0;
                        res_status_reg <= fla_pkg::ST_OK;
                        scan_reg       <= '0;
                        slot_reg       <= '0;
                        slot_done_reg  <= 1'b0;
                        slot_full_reg  <= 1'b0;
                        fit_done_reg   <= 1'b0;
                        found_reg      <= 1'b0;
                        have_prev_reg  <= 1'b0;
                        unique case (op)
                            fla_pkg::OP_ALLOC:  state_reg <= S_A_SCAN;
                            fla_pkg::OP_FREE:   state_reg <= S_F_FIND;
                            fla_pkg::OP_REINIT: state_reg <= S_INIT;
                            default:            state_reg <= S_DONE;
                        endcase
                    end
                end
                S_A_SCAN: begin
                    if (!slot_done_reg) begin
                        if (!al_valid_reg[slot_reg]) begin
                            slot_done_reg <= 1'b1;
                        end else if (slot_reg == AIW'(ALLOC_ENTRIES - 1)) begin
                            slot_done_reg <= 1'b1;
                            slot_full_reg <= 1'b1;
                        end else begin
                            slot_reg <= slot_reg + AIW'(1);
                        end
                    end
                    if (!fit_done_reg) begin
                        if (!scan_live) begin
                            fit_done_reg <= 1'b1;
                        end else begin
                            // strict less keeps the lowest address among ties
                            if (c_fits && (!found_reg || c_left < best_left_reg)) begin
                                found_reg     <= 1'b1;
                                pick_reg      <= scan_reg[FIW-1:0];
                                best_base_reg <= rd_start;
                                best_left_reg <= c_left;
                                best_need_reg <= c_need;
                                best_pad_reg  <= c_pad;
                            end
                            if (c_fits && !fit_policy_reg) fit_done_reg <= 1'b1;
                            else scan_reg <= scan_reg + CW'(1);
                        end
                    end
                    if (fit_done_reg && slot_done_reg) state_reg <= S_A_COMMIT;
                end
                S_A_COMMIT: begin
                    priority if (!found_reg) begin
                        res_status_reg <= fla_pkg::ST_NOFIT;
                    end else if (slot_full_reg) begin
                        res_status_reg <= fla_pkg::ST_FULL;
                    end else begin
                        al_data_reg[slot_reg]  <= new_data_x[A-1:0];
                        al_size_reg[slot_reg]  <= best_need_reg;
                        al_pad_reg[slot_reg]   <= best_pad_reg;
                        al_valid_reg[slot_reg] <= 1'b1;
                        used_reg               <= used_reg + best_need_reg;
                        res_addr_reg           <= new_data_x[A-1:0];
                    end
                    state_reg <= S_DONE;
                end
                S_F_FIND: begin
                    if (al_valid_reg[slot_reg] && al_data_reg[slot_reg] == faddr_reg) begin
                        f_base_reg <= al_data_reg[slot_reg] - al_pad_reg[slot_reg][A-1:0];
                        f_size_reg <= al_size_reg[slot_reg];
                        f_slot_reg <= slot_reg;
                        state_reg  <= S_F_SCAN;
                    end else if (slot_reg == AIW'(ALLOC_ENTRIES - 1)) begin
                        res_status_reg <= fla_pkg::ST_UNKNOWN;
                        state_reg      <= S_DONE;
                    end else begin
                        slot_reg <= slot_reg + AIW'(1);
                    end
                end
                S_F_SCAN: begin
                    if (!scan_live || rd_start >= f_base_reg) begin
                        mp_reg        <= have_prev_reg && (prev_end == {1'b0, f_base_reg});
                        mn_reg        <= scan_live && (f_end == {1'b0, rd_start});
                        next_size_reg <= rd_size;
                        state_reg     <= S_F_COMMIT;
                    end else begin
                        prev_start_reg <= rd_start;
                        prev_size_reg  <= rd_size;
                        have_prev_reg  <= 1'b1;
                        scan_reg       <= scan_reg + CW'(1);
                    end
                end
                S_F_COMMIT: begin
                    if (f_full) begin
                        res_status_reg <= fla_pkg::ST_FULL;
                    end else begin
                        al_valid_reg[f_slot_reg] <= 1'b0;
                        used_reg <= (used_reg >= f_size_reg) ? used_reg - f_size_reg : '0;
                    end
                    state_reg <= S_DONE;
                end
                S_INIT: begin
                    al_valid_reg <= '0;
                    used_reg     <= '0;
                    state_reg    <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_addr_reg   <= res_addr_reg;
                        m_status_reg <= res_status_reg;
                        m_used_reg   <= used_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // free table never holds more blocks than it has entries
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ft_count <= CW'(FREE_ENTRIES))
        else $error("free table count overflow");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("ready after accept");

    // used bytes never exceed the largest arena
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CLW'(used_reg) <= (CLW'(1) << A))
        else $error("used bytes out of range");

    // a full free table never grows on a free
    a_no_grow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_F_COMMIT && f_full) |=> $stable(ft_count))
        else $error("free table grew while full");
endmodule
